// ===== rtl/lookang_pkg.sv =====
// Shared widths, constants and the arctangent table for the look angle pipeline.
package lookang_pkg;

   localparam int DEFAULT_CORDIC_STAGES = 16;
   localparam int XY_W   = 36;   // CORDIC vector width, room for the gain of about 1.65
   localparam int ACC_W  = 35;   // angle accumulator, units of 2pi/2^32
   localparam int ROOT_W = 32;   // square root result width
   localparam int RAD_W  = 64;   // square root operand width

   localparam logic [ACC_W-1:0] HALF_TURN  = ACC_W'(35'h0_8000_0000);
   localparam logic [ACC_W-1:0] EL_LIMIT   = ACC_W'(35'h0_4000_0000);
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(35'h0_0000_8000);
   localparam logic [15:0]      EL_UP      = 16'h4000;
   localparam logic [15:0]      EL_DOWN    = 16'hC000;

   typedef logic signed [XY_W-1:0]  xy_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   // atan(2^-i) in units of 2pi/2^32.
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;
         5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B;
         5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000028;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000002;
         5'd29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/topocentric_look_angles_core.sv =====
// Top level: south/east/zenith vector to slant range, azimuth and elevation.
//
// The req channel takes one vector per beat; the rsp channel returns one
// result beat per request beat, in order. A new vector can enter in
// every cycle while the receiver does not stall, so the sustained rate
// is one beat per cycle. The path runs through a squaring register, a
// summing register, the square root stages (one root bit per stage), a
// CORDIC setup register, CORDIC_STAGES rotation stages and one output
// register. The elevation CORDIC needs the horizontal norm, so it follows
// the square root; that chain sets the latency.
// The zero_vector flag on rsp_tuser marks an all-zero input; both angles
// are then zero. A vector straight up or down gives azimuth zero and a
// quarter turn of elevation.
// Reset clears all valid bits; data registers are not reset.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops in the same cycle; nothing is
// lost or repeated.
module topocentric_look_angles_core #(
   parameter int CORDIC_STAGES = lookang_pkg::DEFAULT_CORDIC_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // south_m[31:0], east_m[63:32], zenith_m[95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // slant_range_m[31:0], azimuth_angle[47:32],
                                    // elevation_angle[63:48]
   output logic [0:0]  rsp_tuser    // zero_vector[0]
);

   localparam int SQRT_LAT = lookang_pkg::ROOT_W;
   localparam int LAT      = 2 + SQRT_LAT + 1 + CORDIC_STAGES + 1;

   typedef struct packed {
      logic signed [31:0] south;
      logic signed [31:0] east;
      logic signed [31:0] zenith;
   } vec_type;

   typedef struct packed {
      logic        se_zero;
      logic        z_zero;
      logic        z_neg;
      logic [31:0] range;
   } side_type;

   logic advance;
   logic valid_ff [LAT];

   assign advance    = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) valid_ff[k] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_tvalid;
         for (int k = 1; k < LAT; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // Squares of the component magnitudes.
   vec_type     in_vec;
   vec_type     v1_ff;
   logic [63:0] sq_s_ff, sq_e_ff, sq_z_ff;
   logic [31:0] mag_s, mag_e, mag_z;

   assign in_vec = '{south: req_tdata[31:0], east: req_tdata[63:32],
                     zenith: req_tdata[95:64]};
   assign mag_s = in_vec.south[31]  ? 32'(-in_vec.south)  : in_vec.south;
   assign mag_e = in_vec.east[31]   ? 32'(-in_vec.east)   : in_vec.east;
   assign mag_z = in_vec.zenith[31] ? 32'(-in_vec.zenith) : in_vec.zenith;

   vec_type     v2_ff;
   logic [63:0] hsq_ff, tot_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         v1_ff   <= in_vec;
         sq_s_ff <= 64'(mag_s) * 64'(mag_s);
         sq_e_ff <= 64'(mag_e) * 64'(mag_e);
         sq_z_ff <= 64'(mag_z) * 64'(mag_z);
         v2_ff   <= v1_ff;
         hsq_ff  <= sq_s_ff + sq_e_ff;
         tot_ff  <= sq_s_ff + sq_e_ff + sq_z_ff;
      end
   end

   logic [31:0] horiz_root, range_root;

   lookang_isqrt u_horiz_sqrt (
      .clock    (clock),
      .enable   (advance),
      .radicand (hsq_ff),
      .root     (horiz_root)
   );

   lookang_isqrt u_range_sqrt (
      .clock    (clock),
      .enable   (advance),
      .radicand (tot_ff),
      .root     (range_root)
   );

   vec_type vd_ff [SQRT_LAT];

   always_ff @(posedge clock) begin
      if (advance) begin
         vd_ff[0] <= v2_ff;
         for (int k = 1; k < SQRT_LAT; k++) vd_ff[k] <= vd_ff[k-1];
      end
   end

   // CORDIC setup. A vector with negative north is turned by a half turn first.
   vec_type              vs;
   lookang_pkg::xy_type  az_x_ff, az_y_ff, el_x_ff, el_y_ff;
   lookang_pkg::acc_type az_a_ff;
   side_type             side_in;
   side_type             side_ff [CORDIC_STAGES + 1];

   assign vs = vd_ff[SQRT_LAT-1];
   assign side_in = '{se_zero: (vs.south == 32'sd0) && (vs.east == 32'sd0),
                      z_zero:  vs.zenith == 32'sd0,
                      z_neg:   vs.zenith[31],
                      range:   range_root};

   always_ff @(posedge clock) begin
      if (advance) begin
         if (vs.south > 32'sd0) begin
            az_x_ff <= lookang_pkg::xy_type'(vs.south);
            az_y_ff <= -lookang_pkg::xy_type'(vs.east);
            az_a_ff <= lookang_pkg::HALF_TURN;
         end else begin
            az_x_ff <= -lookang_pkg::xy_type'(vs.south);
            az_y_ff <= lookang_pkg::xy_type'(vs.east);
            az_a_ff <= '0;
         end
         el_x_ff <= lookang_pkg::xy_type'({4'b0000, horiz_root});
         el_y_ff <= lookang_pkg::xy_type'(vs.zenith);
         side_ff[0] <= side_in;
         for (int k = 1; k <= CORDIC_STAGES; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   lookang_pkg::acc_type az_acc, el_acc;

   lookang_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_az_cordic (
      .clock     (clock),
      .enable    (advance),
      .x_start   (az_x_ff),
      .y_start   (az_y_ff),
      .acc_start (az_a_ff),
      .acc_end   (az_acc)
   );

   lookang_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_el_cordic (
      .clock     (clock),
      .enable    (advance),
      .x_start   (el_x_ff),
      .y_start   (el_y_ff),
      .acc_start ('0),
      .acc_end   (el_acc)
   );

   // Rounding, elevation clamp and the straight up, down and zero cases.
   side_type             so;
   lookang_pkg::acc_type el_clamp, az_round, el_round;
   logic [15:0]          az_in, el_in;
   logic [63:0]          data_ff;
   logic                 flag_ff;

   // The side data sits one register behind the setup stage for each rotation stage.
   assign so = side_ff[CORDIC_STAGES];

   always_comb begin
      if (el_acc > $signed(lookang_pkg::EL_LIMIT)) begin
         el_clamp = lookang_pkg::EL_LIMIT;
      end else if (el_acc < -$signed(lookang_pkg::EL_LIMIT)) begin
         el_clamp = -lookang_pkg::EL_LIMIT;
      end else begin
         el_clamp = el_acc;
      end
      az_round = az_acc + lookang_pkg::ROUND_HALF;
      el_round = el_clamp + lookang_pkg::ROUND_HALF;
      if (so.se_zero) begin
         az_in = '0;
         if (so.z_zero) begin
            el_in = '0;
         end else if (so.z_neg) begin
            el_in = lookang_pkg::EL_DOWN;
         end else begin
            el_in = lookang_pkg::EL_UP;
         end
      end else begin
         az_in = az_round[31:16];
         el_in = el_round[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= {el_in, az_in, so.range};
         flag_ff <= so.se_zero && so.z_zero;
      end
   end

   assign rsp_tdata = data_ff;
   assign rsp_tuser = flag_ff;

endmodule

// ===== rtl/lookang_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module lookang_isqrt (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [lookang_pkg::RAD_W-1:0]    radicand,
   output logic [lookang_pkg::ROOT_W-1:0]   root
);

   localparam int STEPS = lookang_pkg::ROOT_W;
   localparam int REM_W = lookang_pkg::ROOT_W + 4;

   logic [REM_W-1:0]                  rem_ff  [STEPS];
   logic [REM_W-1:0]                  rem_in  [STEPS];
   logic [lookang_pkg::ROOT_W-1:0]    root_ff [STEPS];
   logic [lookang_pkg::ROOT_W-1:0]    root_in [STEPS];
   logic [lookang_pkg::RAD_W-1:0]     num_ff  [STEPS];
   logic [lookang_pkg::RAD_W-1:0]     num_in  [STEPS];

   always_comb begin
      logic [REM_W-1:0]               rem_src;
      logic [lookang_pkg::ROOT_W-1:0] root_src;
      logic [lookang_pkg::RAD_W-1:0]  num_src;
      logic [REM_W-1:0]               pre;
      logic [REM_W-1:0]               trial;
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            rem_src  = '0;
            root_src = '0;
            num_src  = radicand;
         end else begin
            rem_src  = rem_ff[k-1];
            root_src = root_ff[k-1];
            num_src  = num_ff[k-1];
         end
         // Bring down the next two radicand bits and try root bit one.
         pre   = {rem_src[REM_W-3:0], num_src[lookang_pkg::RAD_W-1 -: 2]};
         trial = {2'b00, root_src, 2'b01};
         if (pre >= trial) begin
            rem_in[k]  = pre - trial;
            root_in[k] = {root_src[lookang_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = pre;
            root_in[k] = {root_src[lookang_pkg::ROOT_W-2:0], 1'b0};
         end
         num_in[k] = {num_src[lookang_pkg::RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            num_ff[k]  <= num_in[k];
         end
      end
   end

   assign root = root_ff[STEPS-1];

endmodule

// ===== rtl/lookang_cordic.sv =====
// Pipelined vectoring CORDIC that accumulates the angle of an (x, y) vector.
module lookang_cordic #(
   parameter int CORDIC_STAGES = lookang_pkg::DEFAULT_CORDIC_STAGES
) (
   input  logic                  clock,
   input  logic                  enable,
   input  lookang_pkg::xy_type   x_start,
   input  lookang_pkg::xy_type   y_start,
   input  lookang_pkg::acc_type  acc_start,
   output lookang_pkg::acc_type  acc_end
);

   lookang_pkg::xy_type  x_ff [CORDIC_STAGES];
   lookang_pkg::xy_type  x_in [CORDIC_STAGES];
   lookang_pkg::xy_type  y_ff [CORDIC_STAGES];
   lookang_pkg::xy_type  y_in [CORDIC_STAGES];
   lookang_pkg::acc_type a_ff [CORDIC_STAGES];
   lookang_pkg::acc_type a_in [CORDIC_STAGES];

   always_comb begin
      lookang_pkg::xy_type  xs;
      lookang_pkg::xy_type  ys;
      lookang_pkg::acc_type as;
      lookang_pkg::acc_type step;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         if (k == 0) begin
            xs = x_start;
            ys = y_start;
            as = acc_start;
         end else begin
            xs = x_ff[k-1];
            ys = y_ff[k-1];
            as = a_ff[k-1];
         end
         step = lookang_pkg::acc_type'({3'b000, lookang_pkg::atan_entry(5'(k))});
         if (!ys[lookang_pkg::XY_W-1]) begin
            x_in[k] = xs + (ys >>> k);
            y_in[k] = ys - (xs >>> k);
            a_in[k] = as + step;
         end else begin
            x_in[k] = xs - (ys >>> k);
            y_in[k] = ys + (xs >>> k);
            a_in[k] = as - step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < CORDIC_STAGES; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            a_ff[k] <= a_in[k];
         end
      end
   end

   assign acc_end = a_ff[CORDIC_STAGES-1];

endmodule

// ===== tb/topocentric_look_angles_checker.sv =====
// Checker for the look angle core: predicts each result and compares it with the rsp channel.
module topocentric_look_angles_checker #(
   parameter int CORDIC_STAGES = lookang_pkg::DEFAULT_CORDIC_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,   // south_m[31:0], east_m[63:32], zenith_m[95:64]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // slant_range_m[31:0], azimuth_angle[47:32],
                                    // elevation_angle[63:48]
   input  logic [0:0]  rsp_tuser,   // zero_vector[0]
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               zero_vector;
      logic signed [15:0] elevation_angle;
      logic [15:0]        azimuth_angle;
      logic [31:0]        slant_range_m;
   } look_angles_type;

   look_angles_type look_angles_q[$];

   initial fail_count = 0;
   assign pending_count = look_angles_q.size();

   // Floor square root of a 64-bit value, one result bit at a time.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] probe;
      root = '0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic logic signed [63:0] vector_angle(input logic signed [63:0] x,
         input logic signed [63:0] y, input logic signed [63:0] acc);
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            acc = acc + $signed({32'd0, lookang_pkg::atan_entry(i[4:0])});
         end else begin
            x = x - dx;
            y = y + dy;
            acc = acc - $signed({32'd0, lookang_pkg::atan_entry(i[4:0])});
         end
      end
      return acc;
   endfunction

   function automatic logic [15:0] to_binary_angle(input logic signed [63:0] acc);
      logic signed [63:0] t;
      t = (acc + 64'sd32768) >>> 16;
      return t[15:0];
   endfunction

   function automatic look_angles_type predict_look_angles(input logic [95:0] beat);
      logic signed [63:0] s;
      logic signed [63:0] e;
      logic signed [63:0] z;
      logic signed [63:0] nx;
      logic signed [63:0] ny;
      logic signed [63:0] acc;
      logic [63:0] horiz_sq;
      logic [63:0] root;
      look_angles_type r;
      s = $signed(beat[31:0]);
      e = $signed(beat[63:32]);
      z = $signed(beat[95:64]);
      horiz_sq = s * s + e * e;
      root = floor_sqrt(horiz_sq + z * z);
      r.slant_range_m = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
      r.azimuth_angle = '0;
      r.elevation_angle = '0;
      r.zero_vector = 1'b0;
      if (s == 0 && e == 0) begin
         if (z == 0) r.zero_vector = 1'b1;
         else r.elevation_angle = (z > 0) ? lookang_pkg::EL_UP : lookang_pkg::EL_DOWN;
      end else begin
         nx = -s;
         ny = e;
         acc = '0;
         // Turn the southern half-plane by half a turn so the CORDIC converges.
         if (nx < 0) begin
            nx = -nx;
            ny = -ny;
            acc = 64'sh8000_0000;
         end
         r.azimuth_angle = to_binary_angle(vector_angle(nx, ny, acc));
         acc = vector_angle($signed(floor_sqrt(horiz_sq)), z, 64'sd0);
         if (acc > 64'sh4000_0000) acc = 64'sh4000_0000;
         if (acc < -64'sh4000_0000) acc = -64'sh4000_0000;
         r.elevation_angle = to_binary_angle(acc);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      look_angles_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) look_angles_q.push_back(predict_look_angles(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (look_angles_q.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = look_angles_q.pop_front();
               if (rsp_tdata[31:0] !== want.slant_range_m)
                  report_mismatch("slant_range_m", rsp_tdata[31:0], want.slant_range_m);
               if (rsp_tdata[47:32] !== want.azimuth_angle)
                  report_mismatch("azimuth_angle", rsp_tdata[47:32], want.azimuth_angle);
               if (rsp_tdata[63:48] !== want.elevation_angle)
                  report_mismatch("elevation_angle", $signed(rsp_tdata[63:48]),
                                  want.elevation_angle);
               if (rsp_tuser[0] !== want.zero_vector)
                  report_mismatch("zero_vector", rsp_tuser[0], want.zero_vector);
            end
         end
      end
   end
endmodule

// ===== tb/topocentric_look_angles_core_tb.sv =====
// Testbench top: drives vectors into the look angle core and gives the verdict.
module topocentric_look_angles_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAGES = lookang_pkg::DEFAULT_CORDIC_STAGES;
   localparam int LATENCY = 36 + STAGES;
   localparam int IDLE_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   bit          stimulus_done = 0;
   bit          stall_free = 0;

   always #10 clock = ~clock;

   topocentric_look_angles_core #(.CORDIC_STAGES(STAGES)) u_top (.*);

   topocentric_look_angles_checker #(.CORDIC_STAGES(STAGES)) u_checker (.*);

   // Receiver stalls: stretches of random back-pressure alternate with stall-free stretches.
   always @(negedge clock) begin
      int phase;
      phase = ($time / 20000) % 3;
      if (reset) rsp_tready <= 0;
      else if (stall_free || phase == 0) rsp_tready <= 1;
      else if (phase == 1) rsp_tready <= ($urandom_range(3, 0) != 0);
      else rsp_tready <= ($urandom_range(1, 0) != 0);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] pick_component();
      case ($urandom_range(7, 0))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 0;
         3: return $urandom_range(8, 0) - 4;
         4: return {{16{$urandom_range(1, 0) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_vector(input logic [31:0] s, input logic [31:0] e, input logic [31:0] z);
      req_tdata <= {z, e, s};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_gap();
      req_tvalid <= 0;
      repeat ($urandom_range(6, 1)) @(negedge clock);
   endtask

   initial begin
      logic [31:0] edge_vals[5];
      int burst;
      edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: zero vector, straight up/down, axes, half-plane turns, extremes.
      send_vector(0, 0, 0);
      send_vector(0, 0, 32'd5);
      send_vector(0, 0, -32'd5);
      send_vector(0, 0, 32'h8000_0000);
      send_vector(-32'd100, 0, 0);
      send_vector(32'd100, 0, 0);
      send_vector(0, 32'd100, 0);
      send_vector(0, -32'd100, 0);
      send_vector(32'd100, -32'd3, 32'd7);
      send_vector(32'd100, 32'd3, -32'd7);
      for (int i = 0; i < 15; i++)
         send_vector(edge_vals[i % 5], edge_vals[(i / 5 + i) % 5], edge_vals[(i + 2) % 5]);
      send_gap();
      // Drain once with no stall so every queued result has arrived before going on.
      stall_free = 1;
      while (pending_count != 0) @(negedge clock);
      stall_free = 0;
      for (int n = 0; n < 1800; n += burst) begin
         burst = $urandom_range(40, 1);
         for (int k = 0; k < burst; k++) send_vector(pick_component(), pick_component(),
                                                      pick_component());
         if ($urandom_range(3, 0) != 0) send_gap();
      end
      req_tvalid <= 0;
      stimulus_done = 1;
   end

   initial begin
      wait (stimulus_done);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
